// File: rtl/core/assert_macros.svh
// Assertion macros shared by the scalar multiply core.
// Stand-alone header; expects clk_i and rst_ni in the scope that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on clk_i, disabled while the active-low reset rst_ni is asserted.
`define ECP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Assertion on clk_i that also holds during reset.
`define ECP_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: rtl/core/ecpsm_pkg.sv
// Package for the scalar multiply core: defaults, register indexes, unit status.
// No dependencies.
package ecpsm_pkg;

  localparam int unsigned FIELD_BITS_DEF  = 32;
  localparam int unsigned SCALAR_BITS_DEF = 32;

  localparam int unsigned IO_FIELD_W  = 32;
  localparam int unsigned IN_TDATA_W  = 3 * IO_FIELD_W;
  localparam int unsigned OUT_TDATA_W = 2 * IO_FIELD_W;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PRIME   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_CURVE_A = 1'b1;

  localparam int unsigned PRIME_RST   = 23;
  localparam int unsigned CURVE_A_RST = 1;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

// File: rtl/core/ecpsm_div.sv
// Bit-serial restoring divider: quotient and remainder, one bit per cycle.
// Depends on ecpsm_pkg.
module ecpsm_div import ecpsm_pkg::*; #(
  parameter int unsigned FieldBits = FIELD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [FieldBits-1:0] dividend_i,
  input  logic [FieldBits-1:0] divisor_i,
  output unit_stat_t           stat_o,
  output logic [FieldBits-1:0] quo_o,
  output logic [FieldBits-1:0] rem_o
);

  localparam int unsigned CntW = $clog2(FieldBits + 1);

  logic [FieldBits-1:0] quo_q, rem_q, dvs_q;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q, done_q;
  logic [FieldBits:0]   trial, diff;
  logic                 fit;

  assign trial = {rem_q, quo_q[FieldBits-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fit   = trial >= {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CntW'(FieldBits - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[FieldBits-2:0], fit};
      rem_q <= fit ? diff[FieldBits-1:0] : trial[FieldBits-1:0];
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign quo_o  = quo_q;
  assign rem_o  = rem_q;

endmodule

// File: rtl/core/ecpsm_mul.sv
// Bit-serial modular multiplier, MSB first: double, then conditional add.
// Depends on ecpsm_pkg.
module ecpsm_mul import ecpsm_pkg::*; #(
  parameter int unsigned FieldBits = FIELD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [FieldBits-1:0] a_i,
  input  logic [FieldBits-1:0] b_i,
  input  logic [FieldBits-1:0] mod_i,
  output unit_stat_t           stat_o,
  output logic [FieldBits-1:0] prod_o
);

  localparam int unsigned CntW = $clog2(FieldBits + 1);

  function automatic logic [FieldBits-1:0] add_mod(input logic [FieldBits-1:0] u,
                                                   input logic [FieldBits-1:0] v,
                                                   input logic [FieldBits-1:0] m);
    logic [FieldBits:0] s;
    logic [FieldBits:0] t;
    s = {1'b0, u} + {1'b0, v};
    t = s - {1'b0, m};
    return (s >= {1'b0, m}) ? t[FieldBits-1:0] : s[FieldBits-1:0];
  endfunction

  logic [FieldBits-1:0] acc_q, u_q, v_q, m_q;
  logic [CntW-1:0]      cnt_q;
  logic                 busy_q, done_q, phase_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q  <= 1'b1;
        phase_q <= 1'b0;
        cnt_q   <= '0;
      end else if (busy_q) begin
        phase_q <= ~phase_q;
        if (phase_q) begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CntW'(FieldBits - 1)) begin
            busy_q <= 1'b0;
            done_q <= 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
      u_q   <= a_i;
      v_q   <= b_i;
      m_q   <= mod_i;
    end else if (busy_q) begin
      if (!phase_q) begin
        acc_q <= add_mod(acc_q, acc_q, m_q);
      end else begin
        if (v_q[FieldBits-1]) acc_q <= add_mod(acc_q, u_q, m_q);
        v_q <= {v_q[FieldBits-2:0], 1'b0};
      end
    end
  end

  assign stat_o = '{busy: busy_q, done: done_q};
  assign prod_o = acc_q;

endmodule

// File: rtl/core/ecc_point_scalar_multiply_core.sv
// Elliptic-curve scalar multiply core: sequencer and point-law datapath.
// Depends on ecpsm_pkg, ecpsm_div, ecpsm_mul and assert_macros.svh.
//
// Computes k*P on y^2 = x^3 + a*x + b over GF(p) by LSB-first double-and-add.
// One item is taken at a time. Three bit-serial reductions run on entry,
// then per scalar bit up to one point add and one point double. A point op
// on finite, non-inverse operands runs an extended-Euclid inverse whose
// steps each cost one divide plus one modular multiply, followed by three
// multiplies. An item ends early once the remaining scalar bits are zero;
// most of its run time goes to the bit-serial divider and multiplier.
// A modulus below two gives the point at infinity at once; a zero scalar
// gives it right after the entry reductions.
// Results sit in an output register, so the next item is accepted while the
// previous result waits on m_axis_tready_i. Write prime_modulus and curve_a
// only while the core is idle.
module ecc_point_scalar_multiply_core import ecpsm_pkg::*; #(
  parameter int unsigned FieldBits  = FIELD_BITS_DEF,
  parameter int unsigned ScalarBits = SCALAR_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // input beats
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,  // point_x, point_y, scalar
  input  logic                   s_axis_tuser_i,  // point_at_infinity
  // result beats
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,  // result_x, result_y
  output logic                   m_axis_tuser_o,  // result_at_infinity
  // configuration writes
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

`include "assert_macros.svh"

  localparam int unsigned FB   = FieldBits;
  localparam int unsigned BcW  = $clog2(ScalarBits + 1);
  localparam int unsigned StW  = 5;

  localparam logic [StW-1:0] S_IDLE = 5'd0;
  localparam logic [StW-1:0] S_RX   = 5'd1;
  localparam logic [StW-1:0] S_RY   = 5'd2;
  localparam logic [StW-1:0] S_RA   = 5'd3;
  localparam logic [StW-1:0] S_STEP = 5'd4;
  localparam logic [StW-1:0] S_PA   = 5'd5;
  localparam logic [StW-1:0] S_SQ   = 5'd6;
  localparam logic [StW-1:0] S_N1   = 5'd7;
  localparam logic [StW-1:0] S_N2   = 5'd8;
  localparam logic [StW-1:0] S_N3   = 5'd9;
  localparam logic [StW-1:0] S_INV  = 5'd10;
  localparam logic [StW-1:0] S_EUC  = 5'd11;
  localparam logic [StW-1:0] S_EDIV = 5'd12;
  localparam logic [StW-1:0] S_EMUL = 5'd13;
  localparam logic [StW-1:0] S_LAM  = 5'd14;
  localparam logic [StW-1:0] S_L2   = 5'd15;
  localparam logic [StW-1:0] S_L3   = 5'd16;
  localparam logic [StW-1:0] S_L4   = 5'd17;
  localparam logic [StW-1:0] S_L5   = 5'd18;
  localparam logic [StW-1:0] S_L6   = 5'd19;
  localparam logic [StW-1:0] S_WB   = 5'd20;
  localparam logic [StW-1:0] S_FIN  = 5'd21;

  function automatic logic [FB-1:0] add_mod(input logic [FB-1:0] u,
                                            input logic [FB-1:0] v,
                                            input logic [FB-1:0] m);
    logic [FB:0] s;
    logic [FB:0] t;
    s = {1'b0, u} + {1'b0, v};
    t = s - {1'b0, m};
    return (s >= {1'b0, m}) ? t[FB-1:0] : s[FB-1:0];
  endfunction

  // Operands below m: wrap-around of u - v + m lands in range.
  function automatic logic [FB-1:0] sub_mod(input logic [FB-1:0] u,
                                            input logic [FB-1:0] v,
                                            input logic [FB-1:0] m);
    return (u >= v) ? (u - v) : (u - v + m);
  endfunction

  logic [StW-1:0] state_q, state_d;

  logic [FB-1:0] prime_q, ca_q, cam_q;
  logic [FB-1:0] accx_q, accy_q, runx_q, runy_q, yraw_q;
  logic          accinf_q, runinf_q, added_q, dbl_q;
  logic [ScalarBits-1:0] k_q;
  logic [BcW-1:0]        bitcnt_q;
  logic [FB-1:0] num_q, den_q, tmp_q, lam_q, r0_q, r1_q, c0_q, c1_q;
  logic [FB-1:0] rx_q, ry_q;
  logic          rinf_q;

  logic                  out_valid_q, out_inf_q;
  logic [IO_FIELD_W-1:0] out_x_q, out_y_q;

  // input / output width adaption
  logic [63:0] in_x64, in_y64, in_k64, cfg64, o_x64, o_y64;
  logic [FB-1:0] in_x, in_y;
  logic [ScalarBits-1:0] in_k;

  assign in_x64 = 64'(s_axis_tdata_i[IO_FIELD_W-1:0]);
  assign in_y64 = 64'(s_axis_tdata_i[2*IO_FIELD_W-1:IO_FIELD_W]);
  assign in_k64 = 64'(s_axis_tdata_i[3*IO_FIELD_W-1:2*IO_FIELD_W]);
  assign cfg64  = 64'(cfg_data_i);
  assign in_x   = in_x64[FB-1:0];
  assign in_y   = in_y64[FB-1:0];
  assign in_k   = in_k64[ScalarBits-1:0];
  assign o_x64  = accinf_q ? 64'd0 : 64'(accx_q);
  assign o_y64  = accinf_q ? 64'd0 : 64'(accy_q);

  logic in_acc, cfg_acc, out_load;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign cfg_acc         = cfg_valid_i;
  assign out_load        = (state_q == S_FIN) && (!out_valid_q || m_axis_tready_i);

  // operand selection: add is acc + run, double is run + run
  logic [FB-1:0] sx, sy, tx, ty, neg_ty;
  logic          sinf, tinf;
  assign sx     = dbl_q ? runx_q : accx_q;
  assign sy     = dbl_q ? runy_q : accy_q;
  assign sinf   = dbl_q ? runinf_q : accinf_q;
  assign tx     = runx_q;
  assign ty     = runy_q;
  assign tinf   = runinf_q;
  assign neg_ty = (ty == '0) ? '0 : (prime_q - ty);

  // shared serial units
  unit_stat_t    div_stat, mul_stat;
  logic          div_start, mul_start;
  logic [FB-1:0] div_a, div_b, div_quo, div_rem, mul_a, mul_b, mul_prod, quo_red;

  assign quo_red = (div_quo == prime_q) ? '0 : div_quo;

  ecpsm_div #(.FieldBits(FB)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .dividend_i(div_a), .divisor_i(div_b),
    .stat_o(div_stat), .quo_o(div_quo), .rem_o(div_rem)
  );

  ecpsm_mul #(.FieldBits(FB)) u_mul (
    .clk_i, .rst_ni,
    .start_i(mul_start), .a_i(mul_a), .b_i(mul_b), .mod_i(prime_q),
    .stat_o(mul_stat), .prod_o(mul_prod)
  );

  // sequencer: next state and unit launches
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_a     = r0_q;
    div_b     = prime_q;
    mul_start = 1'b0;
    mul_a     = lam_q;
    mul_b     = tmp_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (prime_q < FB'(2)) begin
            state_d = S_FIN;
          end else begin
            div_start = 1'b1;
            div_a     = in_x;
            state_d   = S_RX;
          end
        end
      end
      S_RX: begin
        if (div_stat.done) begin
          div_start = 1'b1;
          div_a     = yraw_q;
          state_d   = S_RY;
        end
      end
      S_RY: begin
        if (div_stat.done) begin
          div_start = 1'b1;
          div_a     = ca_q;
          state_d   = S_RA;
        end
      end
      S_RA: if (div_stat.done) state_d = S_STEP;
      S_STEP: begin
        if (k_q == '0 || bitcnt_q == BcW'(ScalarBits)) state_d = S_FIN;
        else state_d = S_PA;
      end
      S_PA: begin
        if (sinf || tinf || (sx == tx && sy == neg_ty)) begin
          state_d = S_WB;
        end else if (sx == tx && sy == ty) begin
          mul_start = 1'b1;
          mul_a     = sx;
          mul_b     = sx;
          state_d   = S_SQ;
        end else begin
          state_d = S_INV;
        end
      end
      S_SQ:  if (mul_stat.done) state_d = S_N1;
      S_N1:  state_d = S_N2;
      S_N2:  state_d = S_N3;
      S_N3:  state_d = S_INV;
      S_INV: state_d = S_EUC;
      S_EUC: begin
        if (r1_q == '0) begin
          mul_start = 1'b1;
          mul_a     = num_q;
          mul_b     = c0_q;
          state_d   = S_LAM;
        end else begin
          div_start = 1'b1;
          div_a     = r0_q;
          div_b     = r1_q;
          state_d   = S_EDIV;
        end
      end
      S_EDIV: begin
        if (div_stat.done) begin
          mul_start = 1'b1;
          mul_a     = quo_red;
          mul_b     = c1_q;
          state_d   = S_EMUL;
        end
      end
      S_EMUL: if (mul_stat.done) state_d = S_EUC;
      S_LAM: begin
        if (mul_stat.done) begin
          mul_start = 1'b1;
          mul_a     = mul_prod;
          mul_b     = mul_prod;
          state_d   = S_L2;
        end
      end
      S_L2: if (mul_stat.done) state_d = S_L3;
      S_L3: state_d = S_L4;
      S_L4: state_d = S_L5;
      S_L5: begin
        mul_start = 1'b1;
        state_d   = S_L6;
      end
      S_L6:  if (mul_stat.done) state_d = S_WB;
      S_WB:  state_d = S_STEP;
      S_FIN: if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // control and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      prime_q     <= FB'(PRIME_RST);
      ca_q        <= FB'(CURVE_A_RST);
    end else begin
      state_q <= state_d;
      if (out_load) out_valid_q <= 1'b1;
      else if (m_axis_tready_i) out_valid_q <= 1'b0;
      if (cfg_acc) begin
        case (cfg_index_i)
          CFG_IDX_PRIME:   prime_q <= cfg64[FB-1:0];
          CFG_IDX_CURVE_A: ca_q    <= cfg64[FB-1:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          accx_q   <= '0;
          accy_q   <= '0;
          accinf_q <= 1'b1;
          runinf_q <= s_axis_tuser_i;
          yraw_q   <= in_y;
          k_q      <= in_k;
          bitcnt_q <= '0;
          added_q  <= 1'b0;
        end
      end
      S_RX: if (div_stat.done) runx_q <= div_rem;
      S_RY: if (div_stat.done) runy_q <= div_rem;
      S_RA: if (div_stat.done) cam_q  <= div_rem;
      // add first when the bit is set, then double and advance
      S_STEP: dbl_q <= !(k_q[0] && !added_q);
      S_PA: begin
        if (sinf) begin
          rx_q <= tx; ry_q <= ty; rinf_q <= tinf;
        end else if (tinf) begin
          rx_q <= sx; ry_q <= sy; rinf_q <= sinf;
        end else if (sx == tx && sy == neg_ty) begin
          rx_q <= '0; ry_q <= '0; rinf_q <= 1'b1;
        end else begin
          num_q <= sub_mod(ty, sy, prime_q);
          den_q <= sub_mod(tx, sx, prime_q);
        end
      end
      S_SQ: if (mul_stat.done) tmp_q <= mul_prod;
      S_N1: num_q <= add_mod(tmp_q, tmp_q, prime_q);
      S_N2: num_q <= add_mod(num_q, tmp_q, prime_q);
      S_N3: begin
        num_q <= add_mod(num_q, cam_q, prime_q);
        den_q <= add_mod(sy, sy, prime_q);
      end
      S_INV: begin
        r0_q <= den_q;
        r1_q <= prime_q;
        c0_q <= FB'(1);
        c1_q <= '0;
      end
      S_EDIV: begin
        if (div_stat.done) begin
          r0_q <= r1_q;
          r1_q <= div_rem;
        end
      end
      S_EMUL: begin
        if (mul_stat.done) begin
          c0_q <= c1_q;
          c1_q <= sub_mod(c0_q, mul_prod, prime_q);
        end
      end
      S_LAM: if (mul_stat.done) lam_q <= mul_prod;
      S_L2:  if (mul_stat.done) tmp_q <= sub_mod(mul_prod, sx, prime_q);
      S_L3:  rx_q <= sub_mod(tmp_q, tx, prime_q);
      S_L4:  tmp_q <= sub_mod(sx, rx_q, prime_q);
      S_L6: begin
        if (mul_stat.done) begin
          ry_q   <= sub_mod(mul_prod, sy, prime_q);
          rinf_q <= 1'b0;
        end
      end
      S_WB: begin
        if (dbl_q) begin
          runx_q   <= rx_q;
          runy_q   <= ry_q;
          runinf_q <= rinf_q;
          k_q      <= k_q >> 1;
          bitcnt_q <= bitcnt_q + 1'b1;
          added_q  <= 1'b0;
        end else begin
          accx_q   <= rx_q;
          accy_q   <= ry_q;
          accinf_q <= rinf_q;
          added_q  <= 1'b1;
        end
      end
      default: ;
    endcase
    // hold the result beat until taken
    if (out_load) begin
      out_x_q   <= o_x64[IO_FIELD_W-1:0];
      out_y_q   <= o_y64[IO_FIELD_W-1:0];
      out_inf_q <= accinf_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_y_q, out_x_q};
  assign m_axis_tuser_o  = out_inf_q;

  logic out_zero, fin_free;
  assign out_zero = (out_x_q == '0) && (out_y_q == '0);
  assign fin_free = (state_q == S_FIN) && !out_valid_q;

  `ECP_ASSERT(a_busy_after_accept, in_acc |=> state_q != S_IDLE, "idle after accept")
  `ECP_ASSERT(a_inf_zero_coords, out_valid_q && out_inf_q |-> out_zero, "infinity not zeroed")
  `ECP_ASSERT(a_fin_loads_output, fin_free |=> out_valid_q && state_q == S_IDLE, "no load")

endmodule

// File: dv/tb_ecc_point_scalar_multiply_core.sv
// Self-checking testbench for ecc_point_scalar_multiply_core: random and directed k*P beats.
// Depends on ecpsm_pkg and the core RTL; predicts each result with its own point-law model.
module tb_ecc_point_scalar_multiply_core;
  import ecpsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [63:0] wide_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        inf;
  } ec_pt_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        inf;
    logic [31:0] k;
  } mul_job_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                   s_axis_tuser_i  = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;

  ecc_point_scalar_multiply_core u_top (.*);

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Own copy of the two field registers.
  logic [31:0] mdl_prime = PRIME_RST;
  logic [31:0] mdl_curve_a = CURVE_A_RST;

  mul_job_t job_q[$];     // jobs waiting to be sent
  ec_pt_t   product_q[$]; // predicted k*P, oldest first
  int       n_errors = 0;
  bit       quiet = 1'b0; // no idling in the last stretch

  // ---------------- modular arithmetic and point law ----------------
  function automatic wide_t fadd(wide_t u, wide_t v, wide_t m);
    return (u >= m - v) ? u - (m - v) : u + v;
  endfunction

  function automatic wide_t fsub(wide_t u, wide_t v, wide_t m);
    return (u >= v) ? u - v : u + (m - v);
  endfunction

  function automatic wide_t fmul(wide_t u, wide_t v, wide_t m);
    wide_t acc;
    acc = 0;
    while (v != 0) begin
      if (v[0]) acc = fadd(acc, u, m);
      u = fadd(u, u, m);
      v = v >> 1;
    end
    return acc;
  endfunction

  // Extended Euclid; Bezout coefficient kept mod m, so no inverse gives that coefficient.
  function automatic wide_t finv(wide_t d, wide_t m);
    wide_t r0, r1, c0, c1, quo, rem, nc;
    r0 = d;
    r1 = m;
    c0 = 1 % m;
    c1 = 0;
    while (r1 != 0) begin
      quo = r0 / r1;
      rem = r0 % r1;
      nc  = fsub(c0, fmul(quo % m, c1, m), m);
      r0 = r1;
      r1 = rem;
      c0 = c1;
      c1 = nc;
    end
    return c0;
  endfunction

  function automatic ec_pt_t point_sum(ec_pt_t s, ec_pt_t t, wide_t m, wide_t ca);
    ec_pt_t r;
    wide_t sx, sy, tx, ty, rx;
    wide_t num, den, lam, neg_ty, sq;
    if (s.inf) return t;
    if (t.inf) return s;
    sx = wide_t'(s.x);
    sy = wide_t'(s.y);
    tx = wide_t'(t.x);
    ty = wide_t'(t.y);
    neg_ty = (ty == '0) ? '0 : m - ty;
    if (sx == tx && sy == neg_ty) begin
      r.x = '0;
      r.y = '0;
      r.inf = 1'b1;
      return r;
    end
    if (sx == tx && sy == ty) begin
      sq  = fmul(sx, sx, m);
      num = fadd(fadd(fadd(sq, sq, m), sq, m), ca, m);
      den = fadd(sy, sy, m);
    end else begin
      num = fsub(ty, sy, m);
      den = fsub(tx, sx, m);
    end
    lam = fmul(num, finv(den, m), m);
    rx  = fsub(fsub(fmul(lam, lam, m), sx, m), tx, m);
    r.x = 32'(rx);
    r.y = 32'(fsub(fmul(lam, fsub(sx, rx, m), m), sy, m));
    r.inf = 1'b0;
    return r;
  endfunction

  // LSB-first double-and-add under the current field registers.
  function automatic ec_pt_t scalar_product(mul_job_t j);
    ec_pt_t acc, run;
    wide_t m, ca, k;
    m = wide_t'(mdl_prime);
    k = wide_t'(j.k);
    acc = '{x: '0, y: '0, inf: 1'b1};
    if (m >= 2) begin
      ca = wide_t'(mdl_curve_a) % m;
      run.x = 32'(wide_t'(j.x) % m);
      run.y = 32'(wide_t'(j.y) % m);
      run.inf = j.inf;
      while (k != 0) begin
        if (k[0]) acc = point_sum(acc, run, m, ca);
        run = point_sum(run, run, m, ca);
        k = k >> 1;
      end
    end
    if (acc.inf) begin
      acc.x = '0;
      acc.y = '0;
    end
    return acc;
  endfunction

  // ---------------- input driver ----------------
  int in_gap = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    mul_job_t nxt;
    bit       hold;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      in_gap = 0;
    end else begin
      // Beat taken: predict it and drop it from the pending list.
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        product_q.push_back(scalar_product(job_q[0]));
        void'(job_q.pop_front());
      end
      hold = s_axis_tvalid_i && !s_axis_tready_o;
      if (!hold) begin
        if (in_gap > 0) begin
          in_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (job_q.size() == 0) begin
          s_axis_tvalid_i <= 1'b0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          in_gap = $urandom_range(1, 15);
          s_axis_tvalid_i <= 1'b0;
        end else begin
          nxt = job_q[0];
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {nxt.k, nxt.y, nxt.x};
          s_axis_tuser_i  <= nxt.inf;
        end
      end
    end
  end

  // ---------------- result monitor and receiver stalls ----------------
  int out_stall = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    ec_pt_t want;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      out_stall = 0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (product_q.size() == 0) begin
          $error("result beat with no expected product");
          n_errors++;
        end else begin
          want = product_q.pop_front();
          if (m_axis_tdata_o[31:0] !== want.x) begin
            $error("result_x expected %h actual %h", want.x, m_axis_tdata_o[31:0]);
            n_errors++;
          end
          if (m_axis_tdata_o[63:32] !== want.y) begin
            $error("result_y expected %h actual %h", want.y, m_axis_tdata_o[63:32]);
            n_errors++;
          end
          if (m_axis_tuser_o !== want.inf) begin
            $error("result_at_infinity expected %b actual %b", want.inf, m_axis_tuser_o);
            n_errors++;
          end
        end
      end
      if (out_stall > 0) begin
        out_stall--;
        m_axis_tready_i <= 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall = $urandom_range(1, 15);
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // ---------------- stimulus ----------------
  task automatic add_job(logic [31:0] x, logic [31:0] y, logic inf, logic [31:0] k);
    job_q.push_back('{x: x, y: y, inf: inf, k: k});
  endtask

  // Random point; each scalar is short (0..255) or full 32-bit, full in one draw of full_odds+1.
  task automatic add_random_jobs(int n, int full_odds);
    logic [31:0] k;
    repeat (n) begin
      if ($urandom_range(0, full_odds) == 0) k = $urandom;
      else k = $urandom_range(0, 255);
      add_job($urandom, $urandom, $urandom_range(0, 15) == 0, k);
    end
  endtask

  task automatic wait_drained();
    while (job_q.size() != 0 || s_axis_tvalid_i || product_q.size() != 0) @(posedge clk_i);
  endtask

  // Write one register; the core must be idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_IDX_PRIME) mdl_prime = val;
    else mdl_curve_a = val;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic set_field(logic [31:0] p, logic [31:0] a);
    wait_drained();
    repeat (20) @(posedge clk_i);
    write_reg(CFG_IDX_PRIME, p);
    write_reg(CFG_IDX_CURVE_A, a);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset field: p = 23, a = 1.
    add_job(32'd3, 32'd10, 1'b0, 32'd1);
    add_job(32'd3, 32'd10, 1'b0, 32'd2);
    add_job(32'd3, 32'd10, 1'b0, 32'd0);           // zero scalar
    add_job(32'd3, 32'd10, 1'b1, 32'd7);           // identity base point
    add_job(32'd3, 32'd10, 1'b0, 32'hFFFF_FFFF);
    add_job(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0, 32'd5); // coordinates above p
    add_job(32'd5, 32'd0, 1'b0, 32'd2);            // y = 0 doubling
    add_job(32'd0, 32'd0, 1'b0, 32'd3);
    add_job(32'd3, 32'd10, 1'b0, 32'd28);          // walks through inverse points
    add_job(32'd9, 32'd16, 1'b0, 32'h8000_0000);
    add_random_jobs(25, 1);

    // Largest 32-bit prime, a at its top.
    set_field(32'd4294967291, 32'hFFFF_FFFF);
    add_job(32'hFFFF_FFFF, 32'h0, 1'b0, 32'hFFFF_FFFF);
    add_job(32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 32'd3);
    add_job(32'h0, 32'hFFFF_FFFA, 1'b0, 32'd2);
    add_random_jobs(20, 15);

    // Composite modulus: some slopes have no inverse.
    set_field(32'd15, 32'd0);
    add_random_jobs(15, 2);

    // Degenerate moduli give the identity.
    set_field(32'd1, 32'd5);
    add_job(32'd1, 32'd2, 1'b0, 32'd3);
    add_random_jobs(2, 0);
    set_field(32'd0, 32'd0);
    add_random_jobs(3, 0);

    // Small prime, random a; last stretch runs without idling.
    set_field(32'd97, $urandom);
    add_random_jobs(20, 3);
    while (job_q.size() > 12) @(posedge clk_i);
    quiet = 1'b1;

    wait_drained();
    repeat (200) @(posedge clk_i);
    if (n_errors == 0 && product_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Generous watchdog: a few dozen full-length multiplies with stalls fit many times over.
  initial begin
    #(64'd2_000_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/ecpsm_pkg.sv
rtl/core/ecpsm_div.sv
rtl/core/ecpsm_mul.sv
rtl/core/ecc_point_scalar_multiply_core.sv
dv/tb_ecc_point_scalar_multiply_core.sv
